// ----- rtl/ras_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ras_pkg
// shared constants and types of the ray against box slab test
// ----------------------------------------------------------------------------
package ras_pkg;

  localparam int RAS_FRAC_BITS = 16;
  localparam int RAS_DW        = 32;
  localparam int RAS_AXES      = 3;

  // per-axis status that travels with the slab distances
  typedef struct packed {
    logic zero;     // direction component is zero
    logic outside;  // origin lies outside the two bounds
  } ras_flag_t;

endpackage
`default_nettype wire

// ----- rtl/ras_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ras_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ras_div import ras_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = RAS_DW
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [NW-1:0] quo_o
);

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [NW-1:0] quo_r [NW];
  logic [DW-1:0] den_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] p_rem;
    logic [NW-1:0] p_num;
    logic [NW-1:0] p_quo;
    logic [DW-1:0] p_den;
    logic [DW:0]   sh;
    logic          ge;
    logic [DW:0]   diff;

    if (k == 0) begin : g_first
      assign p_rem = '0;
      assign p_num = num_i;
      assign p_quo = '0;
      assign p_den = den_i;
    end else begin : g_next
      assign p_rem = rem_r[k-1];
      assign p_num = num_r[k-1];
      assign p_quo = quo_r[k-1];
      assign p_den = den_r[k-1];
    end

    assign sh   = {p_rem, p_num[NW-1]};
    assign ge   = (sh >= {1'b0, p_den});
    assign diff = sh - {1'b0, p_den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DW-1:0] : sh[DW-1:0];
        num_r[k] <= {p_num[NW-2:0], 1'b0};
        quo_r[k] <= {p_quo[NW-2:0], ge};
        den_r[k] <= p_den;
      end
    end
  end

  assign quo_o = quo_r[NW-1];

endmodule
`default_nettype wire

// ----- rtl/ras_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ras_lane
// one axis: both slab distances through two pipelined dividers
// ----------------------------------------------------------------------------
module ras_lane import ras_pkg::*; #(
  parameter int FRAC_BITS = RAS_FRAC_BITS,
  parameter int NW        = RAS_DW + FRAC_BITS,
  parameter int TW        = NW + 1
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [31:0]   lo_i,
  input  wire logic signed [31:0]   hi_i,
  input  wire logic signed [31:0]   org_i,
  input  wire logic signed [31:0]   dir_i,
  output logic signed [TW-1:0]      t0_o,
  output logic signed [TW-1:0]      t1_o,
  output ras_flag_t                 flag_o,
  output logic signed [31:0]        org_o,
  output logic signed [31:0]        dir_o
);

  typedef struct packed {
    logic [31:0] org;
    logic [31:0] dir;
    logic        s0;
    logic        s1;
    ras_flag_t   flag;
  } side_t;

  logic signed [32:0] d0, d1, dd;
  logic [32:0] m0, m1, md;
  logic signed [31:0] bmin, bmax;
  side_t side_in;

  assign d0 = {lo_i[31], lo_i} - {org_i[31], org_i};
  assign d1 = {hi_i[31], hi_i} - {org_i[31], org_i};
  assign dd = {dir_i[31], dir_i};
  assign m0 = d0[32] ? -d0 : d0;
  assign m1 = d1[32] ? -d1 : d1;
  assign md = dd[32] ? -dd : dd;
  assign bmin = (lo_i < hi_i) ? lo_i : hi_i;
  assign bmax = (lo_i < hi_i) ? hi_i : lo_i;

  always_comb begin
    side_in.org          = org_i;
    side_in.dir          = dir_i;
    side_in.s0           = d0[32] ^ dir_i[31];
    side_in.s1           = d1[32] ^ dir_i[31];
    side_in.flag.zero    = (dir_i == 32'sd0);
    side_in.flag.outside = (org_i < bmin) || (org_i > bmax);
  end

  // input stage
  logic [NW-1:0] n0_r, n1_r;
  logic [31:0]   dm_r;
  side_t         side_r [NW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      n0_r      <= {m0[31:0], {FRAC_BITS{1'b0}}};
      n1_r      <= {m1[31:0], {FRAC_BITS{1'b0}}};
      dm_r      <= md[31:0];
      side_r[0] <= side_in;
    end
  end

  // side data rides along the divider stages
  for (genvar k = 1; k <= NW; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  logic [NW-1:0] q0, q1;

  ras_div #(.NW(NW), .DW(RAS_DW)) u_div0 (
    .clk(clk), .en(en), .num_i(n0_r), .den_i(dm_r), .quo_o(q0)
  );
  ras_div #(.NW(NW), .DW(RAS_DW)) u_div1 (
    .clk(clk), .en(en), .num_i(n1_r), .den_i(dm_r), .quo_o(q1)
  );

  // sign fix stage, quotient truncated toward zero
  logic signed [TW-1:0] t0_r, t1_r;
  side_t                out_r;
  logic [TW-1:0]        u0, u1;

  assign u0 = {1'b0, q0};
  assign u1 = {1'b0, q1};

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r  <= side_r[NW].s0 ? -u0 : u0;
      t1_r  <= side_r[NW].s1 ? -u1 : u1;
      out_r <= side_r[NW];
    end
  end

  assign t0_o   = t0_r;
  assign t1_o   = t1_r;
  assign flag_o = out_r.flag;
  assign org_o  = out_r.org;
  assign dir_o  = out_r.dir;

endmodule
`default_nettype wire

// ----- rtl/ras_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ras_merge
// combines the lanes: entry, exit, hit decision and the hit point
// ----------------------------------------------------------------------------
module ras_merge import ras_pkg::*; #(
  parameter int FRAC_BITS = RAS_FRAC_BITS,
  parameter int TW        = RAS_DW + FRAC_BITS + 1
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [TW-1:0] t0_i   [RAS_AXES],
  input  wire logic signed [TW-1:0] t1_i   [RAS_AXES],
  input  wire ras_flag_t            flag_i [RAS_AXES],
  input  wire logic signed [31:0]   org_i  [RAS_AXES],
  input  wire logic signed [31:0]   dir_i  [RAS_AXES],
  output logic                      hit_o,
  output logic signed [31:0]        entry_o,
  output logic signed [31:0]        pt_o   [RAS_AXES]
);

  localparam logic signed [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};

  // stage 1: near and far per lane
  logic signed [TW-1:0] tn_r [RAS_AXES];
  logic signed [TW-1:0] tf_r [RAS_AXES];
  ras_flag_t            fl_r [RAS_AXES];
  logic signed [31:0]   o1_r [RAS_AXES];
  logic signed [31:0]   d1_r [RAS_AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < RAS_AXES; a++) begin
        tn_r[a] <= (t0_i[a] < t1_i[a]) ? t0_i[a] : t1_i[a];
        tf_r[a] <= (t0_i[a] < t1_i[a]) ? t1_i[a] : t0_i[a];
        fl_r[a] <= flag_i[a];
        o1_r[a] <= org_i[a];
        d1_r[a] <= dir_i[a];
      end
    end
  end

  // stage 2: reduce over the bounded slabs, saturate the entry
  logic signed [TW-1:0] ent, ext;
  logic                 miss;
  logic signed [31:0]   t_sat;

  always_comb begin
    ent  = T_MIN;
    ext  = T_MAX;
    miss = 1'b0;
    for (int a = 0; a < RAS_AXES; a++) begin
      if (fl_r[a].zero) begin
        if (fl_r[a].outside) miss = 1'b1;
      end else begin
        if (tn_r[a] > ent) ent = tn_r[a];
        if (tf_r[a] < ext) ext = tf_r[a];
      end
    end
    if (ext < ent) miss = 1'b1;
    // no bounded slab leaves ent at its floor, which saturates to the minimum
    if (ent[TW-1:31] == {(TW-31){ent[TW-1]}}) begin
      t_sat = ent[31:0];
    end else begin
      t_sat = ent[TW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  logic               hit2_r;
  logic signed [31:0] t2_r;
  logic signed [31:0] o2_r [RAS_AXES];
  logic signed [31:0] d2_r [RAS_AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      hit2_r <= !miss;
      t2_r   <= t_sat;
      for (int a = 0; a < RAS_AXES; a++) begin
        o2_r[a] <= o1_r[a];
        d2_r[a] <= d1_r[a];
      end
    end
  end

  // stage 3: direction times entry
  logic               hit3_r;
  logic signed [31:0] t3_r;
  logic signed [31:0] o3_r [RAS_AXES];
  logic signed [63:0] pr_r [RAS_AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      hit3_r <= hit2_r;
      t3_r   <= t2_r;
      for (int a = 0; a < RAS_AXES; a++) begin
        o3_r[a] <= o2_r[a];
        pr_r[a] <= d2_r[a] * t2_r;
      end
    end
  end

  // floor shift, add origin, saturate; a miss reports zeros
  always_comb begin
    hit_o   = hit3_r;
    entry_o = hit3_r ? t3_r : 32'sd0;
    for (int a = 0; a < RAS_AXES; a++) begin
      logic signed [63:0] p;
      logic signed [64:0] s;
      p = pr_r[a] >>> FRAC_BITS;
      s = {p[63], p} + {{33{o3_r[a][31]}}, o3_r[a]};
      if (!hit3_r) begin
        pt_o[a] = 32'sd0;
      end else if (s[64:31] == {34{s[64]}}) begin
        pt_o[a] = s[31:0];
      end else begin
        pt_o[a] = s[64] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ray_aabb_slab_test.sv -----
// results leave in request order; coordinates and entry distance are Q16.16 at the default FRAC_BITS
// throughput: one request per cycle while in_tready is high, set by the per-stage dividers of each lane
// each lane's two dividers retire one quotient bit per pipeline stage
// a skid register behind the output keeps input flowing for one stalled result
// reset: synchronous active-low rst_n clears all valid bits, data is not reset
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_aabb_slab_test
// ray against axis-aligned box, three slab lanes and a merge stage
// ----------------------------------------------------------------------------
module ray_aabb_slab_test import ras_pkg::*; #(
  parameter int FRAC_BITS = RAS_FRAC_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // box_min_x/y/z, box_max_x/y/z, ray_origin_x/y/z, ray_dir_x/y/z, 32 bits each
  input  wire logic [383:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // entry_distance, hit_point_x, hit_point_y, hit_point_z, 32 bits each
  output logic [127:0]      out_tdata,
  // hit
  output logic [0:0]        out_tuser
);

  localparam int NW = RAS_DW + FRAC_BITS;
  localparam int TW = NW + 1;
  localparam int PL = NW + 5;

  logic en;
  logic skid_v_r;
  logic [PL-1:0] vld_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PL-2:0], in_tvalid};
    end
  end

  logic signed [TW-1:0] t0 [RAS_AXES];
  logic signed [TW-1:0] t1 [RAS_AXES];
  ras_flag_t            fl [RAS_AXES];
  logic signed [31:0]   org [RAS_AXES];
  logic signed [31:0]   dir [RAS_AXES];

  for (genvar a = 0; a < RAS_AXES; a++) begin : g_lane
    ras_lane #(.FRAC_BITS(FRAC_BITS), .NW(NW), .TW(TW)) u_lane (
      .clk   (clk),
      .en    (en),
      .lo_i  (in_tdata[32*a +: 32]),
      .hi_i  (in_tdata[32*(3+a) +: 32]),
      .org_i (in_tdata[32*(6+a) +: 32]),
      .dir_i (in_tdata[32*(9+a) +: 32]),
      .t0_o  (t0[a]),
      .t1_o  (t1[a]),
      .flag_o(fl[a]),
      .org_o (org[a]),
      .dir_o (dir[a])
    );
  end

  logic               p_hit;
  logic signed [31:0] p_entry;
  logic signed [31:0] p_pt [RAS_AXES];

  ras_merge #(.FRAC_BITS(FRAC_BITS), .TW(TW)) u_merge (
    .clk    (clk),
    .en     (en),
    .t0_i   (t0),
    .t1_i   (t1),
    .flag_i (fl),
    .org_i  (org),
    .dir_i  (dir),
    .hit_o  (p_hit),
    .entry_o(p_entry),
    .pt_o   (p_pt)
  );

  logic [128:0] p_data;
  assign p_data = {p_pt[2], p_pt[1], p_pt[0], p_entry, p_hit};

  logic         p_v;
  logic         out_v_r;
  logic [128:0] out_d_r, skid_d_r;

  assign p_v = en && vld_r[PL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r  <= skid_v_r || p_v;
      skid_v_r <= 1'b0;
    end else if (p_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_d_r <= skid_v_r ? skid_d_r : p_data;
    end else if (p_v) begin
      skid_d_r <= p_data;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r[128:1];
  assign out_tuser  = out_d_r[0:0];

endmodule
`default_nettype wire

// ----- rtl/ras_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ras_checker
// port-level checks of the slab test, bound to the top level
// ----------------------------------------------------------------------------
module ras_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata,
  input wire logic [0:0]   out_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // a miss reports all zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 128'd0)
    else $error("miss with nonzero fields");

  // input only stalls while a result is waiting
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // taken result frees the skid, so input reopens
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && out_tready |=> in_tready)
    else $error("input did not reopen after result taken");

endmodule

bind ray_aabb_slab_test ras_checker u_ras_checker (.*);
`default_nettype wire

// ----- tb/tb_ray_aabb_slab_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_aabb_slab_test
// self-checking bench for the ray against box slab test: random and corner
// boxes and rays are streamed in, each result is checked against a local
// slab-method calculation, with random idling on both sides and a long stall
// ----------------------------------------------------------------------------
module tb_ray_aabb_slab_test;
  import ras_pkg::*;

  localparam int FB = RAS_FRAC_BITS;
  localparam int N_DIRECTED = 20;
  localparam int N_RANDOM = 1450;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        hit;
    logic [31:0] entry;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } slab_res_t;

  class slab_scoreboard;
    slab_res_t pending[$];
    int        n_bad;

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // work out the expected hit, entry and point of one request
    function void note_request(logic [383:0] d);
      longint lo, hi, o[3], dv[3], t0, t1, tn, tf, ent, ext, t, p;
      bit miss, bnd;
      slab_res_t r;
      miss = 0; bnd = 0; ent = 0; ext = 0;
      for (int a = 0; a < 3; a++) begin
        lo = longint'($signed(d[32*a +: 32]));
        hi = longint'($signed(d[32*(3+a) +: 32]));
        o[a] = longint'($signed(d[32*(6+a) +: 32]));
        dv[a] = longint'($signed(d[32*(9+a) +: 32]));
        if (dv[a] == 0) begin
          if (o[a] < (lo < hi ? lo : hi) || o[a] > (lo < hi ? hi : lo)) miss = 1;
        end else begin
          t0 = ((lo - o[a]) * (64'sd1 <<< FB)) / dv[a];
          t1 = ((hi - o[a]) * (64'sd1 <<< FB)) / dv[a];
          tn = t0 < t1 ? t0 : t1;
          tf = t0 < t1 ? t1 : t0;
          if (!bnd) begin
            ent = tn; ext = tf; bnd = 1;
          end else begin
            if (tn > ent) ent = tn;
            if (tf < ext) ext = tf;
          end
        end
      end
      if (bnd && ext < ent) miss = 1;
      r = '0;
      if (!miss) begin
        t = bnd ? sat(ent) : -64'sd2147483648;
        r.hit = 1;
        r.entry = t[31:0];
        for (int a = 0; a < 3; a++) begin
          p = (dv[a] * t) >>> FB;  // arithmetic shift floors
          p = sat(p + o[a]);
          if (a == 0) r.px = p[31:0];
          else if (a == 1) r.py = p[31:0];
          else r.pz = p[31:0];
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic hit, logic [127:0] d);
      slab_res_t e, g;
      g = {hit, d[31:0], d[63:32], d[95:64], d[127:96]};
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %h", g);
        return;
      end
      e = pending.pop_front();
      if (g !== e) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch hit %b/%b entry %h/%h pt %h %h %h / %h %h %h",
                   e.hit, g.hit, e.entry, g.entry, e.px, e.py, e.pz, g.px, g.py, g.pz);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0;
  logic [383:0] in_tdata = '0;
  logic in_tready, out_tvalid;
  logic [127:0] out_tdata;
  logic [0:0] out_tuser;
  bit steady = 0, hold_off = 0, stim_done = 0;
  longint cycles = 0;
  slab_scoreboard sb = new();

  ray_aabb_slab_test u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom();
      default: return 32'($signed($urandom_range(0, 40 << FB)) - (20 << FB));
    endcase
  endfunction

  function logic [31:0] pick_dir();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return $urandom();
      4: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
    endcase
  endfunction

  function logic [383:0] random_request();
    logic [383:0] d;
    for (int i = 0; i < 9; i++) d[32*i +: 32] = pick_coord();
    for (int i = 9; i < 12; i++) d[32*i +: 32] = pick_dir();
    return d;
  endfunction

  // directed: all fields at one extreme, zero directions inside/outside, boxes
  function logic [383:0] directed_request(int k);
    logic [383:0] d;
    logic [31:0] one;
    one = 32'h1 << FB;
    case (k)
      0: d = '0;
      1: d = '1;
      2: d = {12{32'h8000_0000}};
      3: d = {12{32'h7fff_ffff}};
      4: d = {{3{32'h0}}, {3{32'h0}}, {3{one}}, {3{-one}}};              // all zero, inside
      5: d = {{3{32'h0}}, {3{-one}}, {3{one}}, {3{32'h0}}};              // zero, outside
      6: d = {{3{32'h0}}, {3{3*one}}, {3{2*one}}, {3{-one}}};            // zero, outside
      7: d = {{2{32'h0}}, one, {3{32'h0}}, {3{2*one}}, {3{one}}};        // box ahead
      8: d = {{2{32'h0}}, -one, {3{32'h0}}, {3{2*one}}, {3{one}}};       // box behind
      9: d = {{3{one}}, {3{32'h0}}, {3{one}}, {3{-one}}};                // mixed signs
      10: d = {{3{32'h1}}, {3{32'h8000_0000}}, {3{32'h7fff_ffff}}, {3{32'h8000_0000}}};
      11: d = {{3{32'h8000_0000}}, {3{32'h7fff_ffff}}, {3{32'h7fff_ffff}}, {3{32'h8000_0000}}};
      12: d = {one, 32'h0, 32'h0, {3{32'h0}}, {3{one}}, {3{-one}}};     // touching edge
      13: d = {{3{32'h5555_5555}}, {3{32'haaaa_aaaa}}, {3{32'h5555_5555}}, {3{32'haaaa_aaaa}}};
      default: d = random_request();
    endcase
    return d;
  endfunction

  task automatic send(logic [383:0] d);
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_request(d);
  endtask

  task automatic send_all();
    for (int k = 0; k < N_DIRECTED; k++) send(directed_request(k));
    for (int k = 0; k < N_RANDOM; k++) begin
      steady = (k >= 400 && k < 600);
      if (k == 800) hold_off = 1;
      send(random_request());
    end
    in_tvalid <= 0;
  endtask

  // receiver: random stalls, one long hold-off counted here
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser[0], out_tdata);
  end

  initial begin
    int held;
    repeat (7) @(posedge clk);
    while (1) begin
      if (hold_off) begin
        out_tready <= 0;
        held = 0;
        while (held < 300) begin
          @(posedge clk);
          held++;
        end
        hold_off = 0;
      end
      out_tready <= steady || ($urandom_range(0, 99) >= 32);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_aabb_slab_test regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_all();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.n_bad == 0 && sb.pending.size() == 0) begin
      $display("ray_aabb_slab_test regression: pass");
    end else begin
      $display("ray_aabb_slab_test regression: fail");
    end
    $finish;
  end
endmodule
